// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
// Both expect clk_i and rst_ni to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CHK_SAME_CYCLE(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed");

// Consequent checked in the cycle after the antecedent.
`define CHK_NEXT_CYCLE(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== rtl/core/tccs_pkg.sv =====
package tccs_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int LAST_ROW   = COLUMNS * (ROWS - 1);

  // field widths of the item ports
  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int IDX_W    = 11;
  localparam int DATA_W   = 16;
  localparam int CURSOR_W = 11;
  localparam int ATTR_W   = 8;

  localparam int AW    = $clog2(CELL_COUNT);
  localparam int SW_W  = $clog2(CELL_COUNT + 1);
  // cursor and row end may run up to two rows past the screen before a scroll
  localparam int CUR_W = $clog2(CELL_COUNT + 2 * COLUMNS + 1);

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);
  localparam logic [ATTR_W-1:0] ATTR_RESET   = ATTR_W'(8'h57);

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic latch;
    logic sweep;
    logic sweep_copy;
    logic nl_step;
    logic put_write;
    logic scroll_end;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic newline;
    logic at_end;
    logic nl_scroll;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/tccs_ctrl.sv =====
module tccs_ctrl import tccs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output dp_cmd_t    cmd_o,
  input  dp_status_t st_i
);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_CLEAR  = 6'b010000,
    S_POST   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = !((state_q == S_IDLE) && st_i.out_free);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        // zero the store once after reset
        cmd_o.sweep = 1'b1;
        if (st_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i && st_i.out_free) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (st_i.op)
          OP_PUT: begin
            if (st_i.newline) begin
              cmd_o.nl_step = 1'b1;
              if (st_i.nl_scroll) begin
                state_d = S_SCROLL;
              end else begin
                cmd_o.finish = 1'b1;
                state_d      = S_IDLE;
              end
            end else if (st_i.at_end) begin
              // deferred wrap: scroll before the character goes in
              state_d = S_SCROLL;
            end else begin
              cmd_o.put_write = 1'b1;
              cmd_o.finish    = 1'b1;
              state_d         = S_IDLE;
            end
          end
          OP_CLEAR: begin
            state_d = S_CLEAR;
          end
          OP_READ, OP_NONE: begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SCROLL: begin
        cmd_o.sweep      = 1'b1;
        cmd_o.sweep_copy = 1'b1;
        if (st_i.sweep_last) begin
          cmd_o.scroll_end = 1'b1;
          if (st_i.newline) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end else begin
            state_d = S_POST;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (st_i.sweep_last) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_POST: begin
        cmd_o.put_write = 1'b1;
        cmd_o.finish    = 1'b1;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/tccs_dp.sv =====
module tccs_dp import tccs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          st_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [IDX_W-1:0]    cell_index_i,
  input  logic                cfg_we_i,
  input  logic [ATTR_W-1:0]   cfg_wdata_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DATA_W-1:0]   cell_data_o,
  output logic [CURSOR_W-1:0] cursor_position_o
);

  logic [DATA_W-1:0]   mem_q [CELL_COUNT];
  logic [DATA_W-1:0]   rd_q;

  logic [ATTR_W-1:0]   attr_q;
  op_e                 op_q;
  logic [CHAR_W-1:0]   char_q;
  logic                idx_ok_q;

  logic [CUR_W-1:0]    cursor_q, cursor_d;
  logic [CUR_W-1:0]    line_end_q, line_end_d;
  logic [CUR_W-1:0]    cursor_inc;

  logic [SW_W-1:0]     cnt_q, cnt_d;
  logic [SW_W-1:0]     cnt_m1;
  logic [SW_W:0]       src_sum;
  logic                sweep_last;

  logic                out_valid_q;
  logic [DATA_W-1:0]   cell_data_q;
  logic [CURSOR_W-1:0] cursor_out_q;

  logic                re;
  logic [AW-1:0]       raddr;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [DATA_W-1:0]   wdata;
  logic                idx_ok;
  logic                copy_rd;

  // cursor and end of its row
  assign cursor_inc = cursor_q + CUR_W'(1);

  always_comb begin
    cursor_d   = cursor_q;
    line_end_d = line_end_q;
    if (cmd_i.scroll_end) begin
      cursor_d   = CUR_W'(LAST_ROW);
      line_end_d = CUR_W'(CELL_COUNT);
    end else if (cmd_i.put_write) begin
      cursor_d = cursor_inc;
      if (cursor_inc == line_end_q) begin
        line_end_d = line_end_q + CUR_W'(COLUMNS);
      end
    end else if (cmd_i.nl_step) begin
      cursor_d   = line_end_q;
      line_end_d = line_end_q + CUR_W'(COLUMNS);
    end
  end

  // sweep counter: the write uses the read data registered in rd_q, so writes go to cnt-1
  assign sweep_last = (cnt_q == SW_W'(CELL_COUNT));
  assign cnt_m1     = cnt_q - SW_W'(1);
  assign src_sum    = {1'b0, cnt_q} + (SW_W + 1)'(COLUMNS);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.sweep) begin
      cnt_d = sweep_last ? '0 : cnt_q + SW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      line_end_q  <= CUR_W'(COLUMNS);
      cnt_q       <= '0;
      attr_q      <= ATTR_RESET;
      op_q        <= OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q   <= cursor_d;
      line_end_q <= line_end_d;
      cnt_q      <= cnt_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (cmd_i.latch) begin
        op_q <= op_e'(operation_i);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign idx_ok = (cell_index_i < IDX_W'(CELL_COUNT));

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      char_q   <= char_code_i;
      idx_ok_q <= idx_ok;
    end
    if (cmd_i.finish) begin
      cell_data_q  <= ((op_q == OP_READ) && idx_ok_q) ? rd_q : '0;
      cursor_out_q <= cursor_d[CURSOR_W-1:0];
    end
  end

  // store ports
  assign copy_rd = cmd_i.sweep && cmd_i.sweep_copy && (cnt_q < SW_W'(LAST_ROW));

  always_comb begin
    re    = 1'b0;
    raddr = cell_index_i[AW-1:0];
    if (cmd_i.latch) begin
      re = idx_ok;
    end else if (copy_rd) begin
      re    = 1'b1;
      raddr = src_sum[AW-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cursor_q[AW-1:0];
    wdata = {attr_q, char_q};
    if (cmd_i.put_write) begin
      we = 1'b1;
    end else if (cmd_i.sweep && (cnt_q != '0)) begin
      we    = 1'b1;
      waddr = cnt_m1[AW-1:0];
      wdata = (cmd_i.sweep_copy && (cnt_q <= SW_W'(LAST_ROW))) ? rd_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  assign st_o.op         = op_q;
  assign st_o.newline    = (char_q == NEWLINE_CODE);
  assign st_o.at_end     = (cursor_q >= CUR_W'(CELL_COUNT));
  assign st_o.nl_scroll  = (line_end_q >= CUR_W'(CELL_COUNT));
  assign st_o.sweep_last = sweep_last;
  assign st_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign cell_data_o       = cell_data_q;
  assign cursor_position_o = cursor_out_q;

endmodule

// ===== rtl/core/text_console_cursor_scroll_core.sv =====
// Put, read and no-op items: the result is registered from the execute state, and the next
// item is taken only back in idle. Clear: one pass of the single-write-port screen store.
// Put that scrolls: one copy pass, then for a character a write of it in the post state; the copy
// reads one cell and writes one cell a cycle. The result register frees the input side.
// Reset (async, active low) sets cursor, attribute (ATTR_RESET) and handshake state, then the
// store is zeroed in one pass during which no item is taken.
module text_console_cursor_scroll_core import tccs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [IDX_W-1:0]    cell_index_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DATA_W-1:0]   cell_data_o,
  output logic [CURSOR_W-1:0] cursor_position_o,
  input  logic                cfg_we_i,
  input  logic [ATTR_W-1:0]   cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t st;

  tccs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .st_i       (st)
  );

  tccs_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .st_o              (st),
    .operation_i       (operation_i),
    .char_code_i       (char_code_i),
    .cell_index_i      (cell_index_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cell_data_o       (cell_data_o),
    .cursor_position_o (cursor_position_o)
  );

endmodule

// ===== rtl/core/tccs_checker.sv =====
`include "assert_macros.svh"

module tccs_checker import tccs_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [CURSOR_W-1:0] cursor_position_o
);

  // a stalled result stays offered
  `CHK_NEXT_CYCLE(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // one item at a time: busy straight after an input transfer
  `CHK_NEXT_CYCLE(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o)

  // no result can follow in the cycle right after an output transfer
  `CHK_NEXT_CYCLE(a_gap_after_result, out_valid_o && !out_stall_i, !out_valid_o)

  // input is only taken when the result slot is free
  `CHK_SAME_CYCLE(a_slot_free, !in_stall_o, !(out_valid_o && out_stall_i))

  // cursor never reported beyond the pending-wrap position
  `CHK_SAME_CYCLE(a_cursor_range, out_valid_o, cursor_position_o <= CURSOR_W'(CELL_COUNT))

endmodule

bind text_console_cursor_scroll_core tccs_checker u_tccs_checker (.*);

// ===== tb/tb_text_console_cursor_scroll_core.sv =====
module tb_text_console_cursor_scroll_core;
  import tccs_pkg::*;

  typedef struct {
    logic [DATA_W-1:0]   data;
    logic [CURSOR_W-1:0] cursor;
  } console_result_t;

  // Screen mirror: predicts the cell and cursor reported for each transfer.
  class console_scoreboard;
    logic [DATA_W-1:0] cells [CELL_COUNT];
    int unsigned       cursor;
    logic [ATTR_W-1:0] attr;
    console_result_t   expected_q [$];
    int                errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cursor = 0;
      attr   = ATTR_RESET;
      errors = 0;
    endfunction

    function void set_attr(logic [ATTR_W-1:0] v);
      attr = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void scroll_rows();
      for (int i = 0; i < LAST_ROW; i++) cells[i] = cells[i + COLUMNS];
      for (int i = LAST_ROW; i < CELL_COUNT; i++) cells[i] = '0;
      cursor = LAST_ROW;
    endfunction

    function void note_input(op_e op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
      console_result_t res;
      res.data = '0;
      case (op)
        OP_PUT: begin
          if (ch == NEWLINE_CODE) cursor = (cursor / COLUMNS) * COLUMNS + COLUMNS;
          // deferred wrap: a pending cursor past the screen scrolls first
          if (cursor >= CELL_COUNT) scroll_rows();
          if (ch != NEWLINE_CODE) begin
            cells[cursor] = {attr, ch};
            cursor++;
          end
        end
        OP_CLEAR: begin
          foreach (cells[i]) cells[i] = '0;
        end
        OP_READ: begin
          if (idx < CELL_COUNT) res.data = cells[idx];
        end
        default: ;
      endcase
      res.cursor = CURSOR_W'(cursor);
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [DATA_W-1:0] data, logic [CURSOR_W-1:0] cur);
      console_result_t res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result data %h cursor %0d", $time, data, cur);
        errors++;
        return;
      end
      res = expected_q.pop_front();
      if (data !== res.data) begin
        $display("%0t: cell_data expected %h got %h", $time, res.data, data);
        errors++;
      end
      if (cur !== res.cursor) begin
        $display("%0t: cursor_position expected %0d got %0d", $time, res.cursor, cur);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OP_W-1:0]     operation_i;
  logic [CHAR_W-1:0]   char_code_i;
  logic [IDX_W-1:0]    cell_index_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [DATA_W-1:0]   cell_data_o;
  logic [CURSOR_W-1:0] cursor_position_o;
  logic                cfg_we_i;
  logic [ATTR_W-1:0]   cfg_wdata_i;

  console_scoreboard sb;
  bit                no_idle  = 1'b0;
  bit                hold_req = 1'b0;

  text_console_cursor_scroll_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .char_code_i       (char_code_i),
    .cell_index_i      (cell_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cell_data_o       (cell_data_o),
    .cursor_position_o (cursor_position_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Worst case: every item scrolling, plus stalls and the clearing pass, several times over.
  initial begin
    #70_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: short random stalls, and one long hold-off on request.
  initial begin
    int n;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(cell_data_o, cursor_position_o);
  end

  function automatic logic [CHAR_W-1:0] printable();
    logic [CHAR_W-1:0] ch;
    do ch = CHAR_W'($urandom_range(0, 255)); while (ch == NEWLINE_CODE);
    return ch;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 3))
      0: return IDX_W'($urandom_range(0, 2047));
      1: return IDX_W'(sb.cursor > 0 ? sb.cursor - 1 : 0);
      2: return IDX_W'(LAST_ROW + $urandom_range(0, COLUMNS - 1));
      default: return IDX_W'($urandom_range(0, CELL_COUNT - 1));
    endcase
  endfunction

  task automatic send_item(op_e op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
    int n;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    operation_i  <= op;
    char_code_i  <= ch;
    cell_index_i <= idx;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, ch, idx);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_attr(logic [ATTR_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_attr(v);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly text lines and newline runs so the screen fills and scrolls; reads,
  // row fills (pending wrap on the last row), clears and unused codes mixed in.
  task automatic run_random(int count);
    int done, kind, n;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        n = $urandom_range(0, 12);
        repeat (n) send_item(OP_PUT, printable(), IDX_W'($urandom_range(0, 2047)));
        send_item(OP_PUT, NEWLINE_CODE, IDX_W'($urandom_range(0, 2047)));
        done += n + 1;
      end else if (kind < 41) begin
        n = COLUMNS - (sb.cursor % COLUMNS);
        repeat (n) send_item(OP_PUT, printable(), IDX_W'($urandom_range(0, 2047)));
        done += n;
      end else if (kind < 56) begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(OP_READ, CHAR_W'($urandom_range(0, 255)), pick_index());
        done += n;
      end else if (kind < 66) begin
        send_item(OP_PUT, CHAR_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 2047)));
        done++;
      end else if (kind < 69) begin
        send_item(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 2047)));
        done++;
      end else if (kind < 73) begin
        send_item(OP_NONE, CHAR_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 2047)));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(OP_PUT, NEWLINE_CODE, IDX_W'($urandom_range(0, 2047)));
        done += n;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    operation_i  <= OP_PUT;
    char_code_i  <= '0;
    cell_index_i <= '0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contents, range edges, char extremes, newline, clear
    send_item(OP_READ, 8'h00, IDX_W'(0));
    send_item(OP_READ, 8'hFF, IDX_W'(CELL_COUNT - 1));
    send_item(OP_READ, 8'h00, IDX_W'(CELL_COUNT));
    send_item(OP_READ, 8'h00, '1);
    send_item(OP_PUT, 8'h41, '0);
    send_item(OP_PUT, 8'hFF, '1);
    send_item(OP_PUT, 8'h00, '0);
    send_item(OP_PUT, 8'h80, '0);
    send_item(OP_PUT, 8'h7F, '0);
    send_item(OP_READ, 8'h00, IDX_W'(0));
    send_item(OP_READ, 8'h00, IDX_W'(1));
    send_item(OP_READ, 8'h00, IDX_W'(3));
    send_item(OP_NONE, 8'hFF, '1);
    send_item(OP_PUT, NEWLINE_CODE, '0);
    send_item(OP_PUT, 8'h55, '0);
    send_item(OP_READ, 8'h00, IDX_W'(COLUMNS));
    send_item(OP_PUT, NEWLINE_CODE, '0);
    send_item(OP_CLEAR, 8'h00, '0);
    send_item(OP_READ, 8'h00, IDX_W'(0));
    send_item(OP_READ, 8'h00, IDX_W'(COLUMNS));
    send_item(OP_PUT, NEWLINE_CODE, '1);
    send_item(OP_READ, 8'hFF, '1);
    send_item(OP_NONE, 8'h00, '0);
    wait_idle();

    write_attr(8'h00);
    run_random(250);
    wait_idle();

    write_attr(8'hFF);
    hold_req = 1'b1;
    run_random(250);
    wait_idle();

    write_attr(ATTR_W'($urandom_range(0, 255)));
    run_random(250);
    wait_idle();

    write_attr(ATTR_W'($urandom_range(0, 255)));
    no_idle = 1'b1;
    run_random(250);
    wait_idle();
    repeat (10) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tccs_pkg.sv
rtl/core/tccs_ctrl.sv
rtl/core/tccs_dp.sv
rtl/core/text_console_cursor_scroll_core.sv
rtl/core/tccs_checker.sv
tb/tb_text_console_cursor_scroll_core.sv
